[design/iecmon_pkg.sv]
`default_nettype none
package iecmon_pkg;

   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int TRANS_DEPTH = 65536;
   localparam int HIST_DEPTH = 256;
   localparam int OUT_DEPTH = 4;

   localparam logic [1:0] FMT_I = 2'd0;
   localparam logic [1:0] FMT_S = 2'd1;
   localparam logic [1:0] FMT_U = 2'd2;

   localparam logic [2:0] UFN_NONE = 3'd0;
   localparam logic [2:0] UFN_STARTDT_ACT = 3'd1;
   localparam logic [2:0] UFN_STARTDT_CON = 3'd2;
   localparam logic [2:0] UFN_STOPDT_ACT = 3'd3;
   localparam logic [2:0] UFN_STOPDT_CON = 3'd4;
   localparam logic [2:0] UFN_TESTFR_ACT = 3'd5;
   localparam logic [2:0] UFN_TESTFR_CON = 3'd6;

   localparam logic [1:0] CSR_ALLOW_LOW = 2'd0;
   localparam logic [1:0] CSR_ALLOW_HIGH = 2'd1;
   localparam logic [1:0] CSR_LEARN = 2'd2;

   localparam logic [15:0] WRAP_DIST = 16'd32768;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK
   } bk_state_type;

   typedef struct packed {
      logic        fwd;
      logic        first;
      logic        len_zero;
      logic        len_ge4;
      logic        len_ge6;
      logic [1:0]  fmt;
      logic [2:0]  ufn;
      logic [14:0] tx;
      logic [14:0] rx;
      logic [7:0]  tid;
      logic [63:0] time_us;
      logic [31:0] age_ms;
   } item_type;

   typedef struct packed {
      logic [1:0]  apdu_format;
      logic [2:0]  u_function;
      logic        ack_delay_valid;
      logic [63:0] ack_delay_us;
      logic [15:0] recv_seq;
      logic [14:0] send_seq;
      logic [31:0] lost_send_total;
      logic [31:0] lost_recv_total;
      logic        retransmitted;
      logic        transition_alert;
      logic        type_alert;
      logic        stop_packet;
   } result_type;

   typedef struct packed {
      logic clearing;
   } bk_status_type;

endpackage
`default_nettype wire

[design/iecmon_front.sv]
`default_nettype none
module iecmon_front
   import iecmon_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic          from_initiator,
   input  wire logic          first_of_packet,
   input  wire logic [7:0]    apdu_len,
   input  wire logic [7:0]    ctrl_one,
   input  wire logic [7:0]    ctrl_two,
   input  wire logic [7:0]    ctrl_three,
   input  wire logic [7:0]    ctrl_four,
   input  wire logic [7:0]    type_id,
   input  wire logic [63:0]   time_us,
   input  wire logic [31:0]   flow_age_ms,
   input  wire bk_status_type bk_status,
   output logic               q_valid,
   output item_type           q_item,
   input  wire logic          q_take
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   dec;
   logic       acc;
   logic [14:0] tx_raw, rx_raw;

   always_comb begin
      dec = '0;
      tx_raw = {ctrl_two, ctrl_one[7:1]};
      rx_raw = {ctrl_four, ctrl_three[7:1]};
      dec.fwd = from_initiator;
      dec.first = first_of_packet;
      dec.len_zero = apdu_len == 8'd0;
      dec.len_ge4 = apdu_len >= 8'd4;
      dec.len_ge6 = apdu_len >= 8'd6;
      if (!ctrl_one[0]) dec.fmt = FMT_I;
      else if (!ctrl_one[1]) dec.fmt = FMT_S;
      else dec.fmt = FMT_U;
      dec.ufn = UFN_NONE;
      if (dec.fmt == FMT_U) begin
         case (ctrl_one[7:2])
            6'h01: dec.ufn = UFN_STARTDT_ACT;
            6'h02: dec.ufn = UFN_STARTDT_CON;
            6'h04: dec.ufn = UFN_STOPDT_ACT;
            6'h08: dec.ufn = UFN_STOPDT_CON;
            6'h10: dec.ufn = UFN_TESTFR_ACT;
            6'h20: dec.ufn = UFN_TESTFR_CON;
            default: dec.ufn = UFN_NONE;
         endcase
      end
      // The reverse direction sees the peer's numbers, so the two swap.
      dec.tx = from_initiator ? tx_raw : rx_raw;
      dec.rx = from_initiator ? rx_raw : tx_raw;
      dec.tid = type_id;
      dec.time_us = time_us;
      dec.age_ms = flow_age_ms;
   end

   assign full = bk_status.clearing || count_ff == 2'd2;
   assign acc = push && !full;
   assign q_valid = count_ff != 2'd0;
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ acc;
      rd_ptr_in = rd_ptr_ff ^ q_take;
      count_in = count_ff + {1'b0, acc} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) slot_ff[wr_ptr_ff] <= dec;
   end

endmodule
`default_nettype wire

[design/iecmon_back.sv]
`default_nettype none
module iecmon_back
   import iecmon_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output logic             q_take,
   output bk_status_type    bk_status,
   output logic             out_empty,
   output result_type       out_head,
   input  wire logic        out_pop
);

   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

   logic [63:0] allow_low_ff, allow_high_ff;
   logic [31:0] learn_ff;

   bk_state_type state_ff, state_in;
   logic [16:0]  clr_ff, clr_in;

   logic [63:0] last_time_ff, last_time_in;
   logic        last_valid_ff, last_valid_in;
   logic [7:0]  prev_ff, prev_in;
   logic [14:0] send_ff, send_in;
   logic [15:0] recv_ff, recv_in;
   logic [31:0] lost_send_ff, lost_send_in, lost_recv_ff, lost_recv_in;
   logic [COUNTER_WIDTH-1:0] dir_ff [2];
   logic [COUNTER_WIDTH-1:0] fmt_cnt_ff [4];
   logic [COUNTER_WIDTH-1:0] retx_cnt_ff;

   logic [COUNTER_WIDTH-1:0] trans_mem [TRANS_DEPTH];
   logic [COUNTER_WIDTH-1:0] hist_mem [HIST_DEPTH];
   logic [COUNTER_WIDTH-1:0] trans_rd_ff, hist_rd_ff;

   result_type  res_ff, res_in, res_out;
   logic        do_trans_ff, do_hist_ff;
   logic [15:0] key_ff;
   logic [7:0]  tid_ff;
   logic [31:0] age_ff;

   result_type  fifo_ff [OUT_DEPTH];
   logic [1:0]  fwr_ff, frd_ff;
   logic [2:0]  fcnt_ff;

   item_type h;
   logic start, is_i, is_s, is_u, seq_path, retx, upd, initial_seq;
   logic [16:0] a_s, b_s;
   logic [15:0] d_send, d_recv, rx16, new_recv;
   logic [32:0] sum_send, sum_recv;
   logic [127:0] mask;
   logic talert, out_push;
   logic tr_we, hi_we;
   logic [15:0] tr_waddr;
   logic [7:0]  hi_waddr;
   logic [COUNTER_WIDTH-1:0] tr_wdata, hi_wdata;

   function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   assign h = q_item;
   assign bk_status.clearing = state_ff == BK_CLEAR;
   assign mask = {allow_high_ff, allow_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_low_ff <= '1;
         allow_high_ff <= '1;
         learn_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALLOW_LOW: allow_low_ff <= csr_wdata;
            CSR_ALLOW_HIGH: allow_high_ff <= csr_wdata;
            CSR_LEARN: learn_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // First stage of an item: everything but the table lookups.
   always_comb begin
      start = state_ff == BK_IDLE && q_valid && fcnt_ff != 3'(OUT_DEPTH);
      q_take = start;
      is_i = !h.len_zero && h.fmt == FMT_I;
      is_s = !h.len_zero && h.fmt == FMT_S;
      is_u = !h.len_zero && h.fmt == FMT_U;
      seq_path = is_i && h.len_ge6;
      retx = seq_path && h.tx == send_ff && {1'b0, h.rx} == recv_ff;
      upd = seq_path && !retx;
      initial_seq = send_ff == 15'd0 && recv_ff == 16'd0;
      a_s = {2'b00, h.tx};
      b_s = {1'b0, {1'b0, send_ff} + 16'd1};
      d_send = a_s >= b_s ? 16'(a_s - b_s) : 16'(b_s - a_s);
      rx16 = {1'b0, h.rx};
      d_recv = rx16 >= recv_ff ? rx16 - recv_ff : recv_ff - rx16;
      sum_send = {1'b0, lost_send_ff} + {17'd0, d_send};
      sum_recv = {1'b0, lost_recv_ff} + {17'd0, d_recv};
      new_recv = h.fwd ? rx16 : rx16 + 16'd1;

      last_time_in = last_time_ff;
      last_valid_in = last_valid_ff;
      prev_in = prev_ff;
      send_in = send_ff;
      recv_in = recv_ff;
      lost_send_in = lost_send_ff;
      lost_recv_in = lost_recv_ff;
      if (start && is_i) begin
         last_time_in = h.time_us;
         last_valid_in = 1'b1;
      end
      if (start && upd) begin
         if (!initial_seq) begin
            if (d_send != WRAP_DIST)
               lost_send_in = sum_send[32] ? 32'hFFFF_FFFF : sum_send[31:0];
            if (d_recv != WRAP_DIST)
               lost_recv_in = sum_recv[32] ? 32'hFFFF_FFFF : sum_recv[31:0];
         end
         send_in = h.tx;
         recv_in = new_recv;
         prev_in = h.tid;
      end

      res_in = '0;
      res_in.apdu_format = h.fmt;
      res_in.u_function = is_u ? h.ufn : UFN_NONE;
      res_in.ack_delay_valid = is_s && h.len_ge4 && last_valid_ff;
      res_in.ack_delay_us = res_in.ack_delay_valid ? h.time_us - last_time_ff : 64'd0;
      res_in.recv_seq = recv_in;
      res_in.send_seq = send_in;
      res_in.lost_send_total = lost_send_in;
      res_in.lost_recv_total = lost_recv_in;
      res_in.retransmitted = retx;
      res_in.type_alert = upd && !h.tid[7] && !mask[h.tid[6:0]];
      res_in.stop_packet = h.len_zero || (is_i && !h.len_ge6) || retx;
   end

   // Second stage: table read data is back, finish and write.
   always_comb begin
      talert = do_trans_ff && trans_rd_ff == '0 && age_ff > learn_ff;
      res_out = res_ff;
      res_out.transition_alert = talert;
      out_push = state_ff == BK_LOOK;
      tr_we = 1'b0;
      tr_waddr = key_ff;
      tr_wdata = sat_inc(trans_rd_ff);
      hi_we = 1'b0;
      hi_waddr = tid_ff;
      hi_wdata = sat_inc(hist_rd_ff);
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         BK_CLEAR: begin
            tr_we = 1'b1;
            tr_waddr = clr_ff[15:0];
            tr_wdata = '0;
            hi_we = 1'b1;
            hi_waddr = clr_ff[7:0];
            hi_wdata = '0;
            clr_in = clr_ff + 17'd1;
            if (clr_ff == 17'(TRANS_DEPTH - 1)) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (start) state_in = BK_LOOK;
         end
         BK_LOOK: begin
            tr_we = do_trans_ff;
            if (trans_rd_ff == '0)
               tr_wdata = (age_ff > learn_ff) ? COUNTER_WIDTH'(2) : COUNTER_WIDTH'(1);
            hi_we = do_hist_ff;
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff <= '0;
         last_time_ff <= '0;
         last_valid_ff <= 1'b0;
         prev_ff <= '0;
         send_ff <= '0;
         recv_ff <= '0;
         lost_send_ff <= '0;
         lost_recv_ff <= '0;
         retx_cnt_ff <= '0;
         for (int i = 0; i < 2; i++) dir_ff[i] <= '0;
         for (int i = 0; i < 4; i++) fmt_cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         last_time_ff <= last_time_in;
         last_valid_ff <= last_valid_in;
         prev_ff <= prev_in;
         send_ff <= send_in;
         recv_ff <= recv_in;
         lost_send_ff <= lost_send_in;
         lost_recv_ff <= lost_recv_in;
         if (start) begin
            if (h.first) dir_ff[!h.fwd] <= sat_inc(dir_ff[!h.fwd]);
            if (is_i) fmt_cnt_ff[0] <= sat_inc(fmt_cnt_ff[0]);
            if (is_s) fmt_cnt_ff[1] <= sat_inc(fmt_cnt_ff[1]);
            if (is_u) fmt_cnt_ff[2] <= sat_inc(fmt_cnt_ff[2]);
            if (is_s || is_u) fmt_cnt_ff[3] <= sat_inc(fmt_cnt_ff[3]);
            if (retx) retx_cnt_ff <= sat_inc(retx_cnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         res_ff <= res_in;
         do_trans_ff <= upd && !initial_seq;
         do_hist_ff <= upd;
         key_ff <= {prev_ff, h.tid};
         tid_ff <= h.tid;
         age_ff <= h.age_ms;
         trans_rd_ff <= trans_mem[{prev_ff, h.tid}];
         hist_rd_ff <= hist_mem[h.tid];
      end
      if (tr_we) trans_mem[tr_waddr] <= tr_wdata;
      if (hi_we) hist_mem[hi_waddr] <= hi_wdata;
   end

   // Result queue.
   logic fpop;
   assign out_empty = fcnt_ff == 3'd0;
   assign fpop = out_pop && !out_empty;
   assign out_head = fifo_ff[frd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         fwr_ff <= '0;
         frd_ff <= '0;
         fcnt_ff <= '0;
      end else begin
         if (out_push) fwr_ff <= fwr_ff + 2'd1;
         if (fpop) frd_ff <= frd_ff + 2'd1;
         fcnt_ff <= fcnt_ff + {2'd0, out_push} - {2'd0, fpop};
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) fifo_ff[fwr_ff] <= res_out;
   end

   a_no_start_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_CLEAR |-> !q_take) else $error("item taken during clear");
   a_look_follows: assert property (@(posedge clock) disable iff (reset)
      q_take |=> state_ff == BK_LOOK) else $error("start not followed by lookup");
   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_LOOK |-> fcnt_ff != 3'(OUT_DEPTH)) else $error("result queue overflow");
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= 3'(OUT_DEPTH)) else $error("result count out of range");

endmodule
`default_nettype wire

[design/iec104_apdu_sequence_monitor_top.sv]
`default_nettype none
// Channel   Ports                    Direction  Handshake
// request   req_* fields             in         push && !full
// result    rsp_* fields             out        pop && !empty
// config    csr_we/index/wdata       in         write when csr_we
//
// Each request first reads the transition and histogram tables, then writes
// them back; a new request is taken only once the write-back is done. A
// pushed request is registered in the request queue, then in the stage
// registers, then in the result queue. After reset a clearing pass zeroes
// the tables, and full stays high meanwhile. A two-entry request queue and
// a four-entry result queue let either side stall without the other.
module iec104_apdu_sequence_monitor_top
   import iecmon_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_from_initiator,
   input  wire logic        req_first_of_packet,
   input  wire logic [7:0]  req_apdu_len,
   input  wire logic [7:0]  req_ctrl_one,
   input  wire logic [7:0]  req_ctrl_two,
   input  wire logic [7:0]  req_ctrl_three,
   input  wire logic [7:0]  req_ctrl_four,
   input  wire logic [7:0]  req_type_id,
   input  wire logic [63:0] req_time_us,
   input  wire logic [31:0] req_flow_age_ms,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_apdu_format,
   output logic [2:0]       rsp_u_function,
   output logic             rsp_ack_delay_valid,
   output logic [63:0]      rsp_ack_delay_us,
   output logic [15:0]      rsp_recv_seq,
   output logic [14:0]      rsp_send_seq,
   output logic [31:0]      rsp_lost_send_total,
   output logic [31:0]      rsp_lost_recv_total,
   output logic             rsp_retransmitted,
   output logic             rsp_transition_alert,
   output logic             rsp_type_alert,
   output logic             rsp_stop_packet,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   bk_status_type bk_status;
   logic          q_valid, q_take;
   item_type      q_item;
   result_type    head;

   iecmon_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .from_initiator(req_from_initiator), .first_of_packet(req_first_of_packet),
      .apdu_len(req_apdu_len), .ctrl_one(req_ctrl_one), .ctrl_two(req_ctrl_two),
      .ctrl_three(req_ctrl_three), .ctrl_four(req_ctrl_four),
      .type_id(req_type_id), .time_us(req_time_us), .flow_age_ms(req_flow_age_ms),
      .bk_status(bk_status), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
   );

   iecmon_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
      .bk_status(bk_status), .out_empty(empty), .out_head(head), .out_pop(pop)
   );

   assign rsp_apdu_format = head.apdu_format;
   assign rsp_u_function = head.u_function;
   assign rsp_ack_delay_valid = head.ack_delay_valid;
   assign rsp_ack_delay_us = head.ack_delay_us;
   assign rsp_recv_seq = head.recv_seq;
   assign rsp_send_seq = head.send_seq;
   assign rsp_lost_send_total = head.lost_send_total;
   assign rsp_lost_recv_total = head.lost_recv_total;
   assign rsp_retransmitted = head.retransmitted;
   assign rsp_transition_alert = head.transition_alert;
   assign rsp_type_alert = head.type_alert;
   assign rsp_stop_packet = head.stop_packet;

endmodule
`default_nettype wire

[sim/iec104_apdu_sequence_monitor_top_test.sv]
`timescale 1ns / 1ps
module iec104_apdu_sequence_monitor_top_test;
   import iecmon_pkg::*;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_from_initiator;
   logic        req_first_of_packet;
   logic [7:0]  req_apdu_len;
   logic [7:0]  req_ctrl_one;
   logic [7:0]  req_ctrl_two;
   logic [7:0]  req_ctrl_three;
   logic [7:0]  req_ctrl_four;
   logic [7:0]  req_type_id;
   logic [63:0] req_time_us;
   logic [31:0] req_flow_age_ms;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_apdu_format;
   logic [2:0]  rsp_u_function;
   logic        rsp_ack_delay_valid;
   logic [63:0] rsp_ack_delay_us;
   logic [15:0] rsp_recv_seq;
   logic [14:0] rsp_send_seq;
   logic [31:0] rsp_lost_send_total;
   logic [31:0] rsp_lost_recv_total;
   logic        rsp_retransmitted;
   logic        rsp_transition_alert;
   logic        rsp_type_alert;
   logic        rsp_stop_packet;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   iec104_apdu_sequence_monitor_top i_dut (.*);

   // Mirror of the monitor's state and registers.
   logic [63:0] allow_low;
   logic [63:0] allow_high;
   logic [31:0] learn_ms;
   logic [63:0] last_i_time;
   logic        last_i_valid;
   logic [7:0]  prev_tid;
   logic [15:0] send_seq_m;
   logic [15:0] recv_seq_m;
   logic [31:0] lost_send_m;
   logic [31:0] lost_recv_m;
   bit          seen_transition [int];

   result_type  expected_results [$];
   int          tx_idle_pct;
   int          rx_idle_pct;
   int          hold_cycles;
   int          errors;
   logic [63:0] clock_us;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] add_lost(logic [31:0] acc, logic [63:0] d);
      logic [63:0] s;
      s = {32'd0, acc} + d;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic result_type predict_apdu(logic fwd, logic [7:0] len, logic [7:0] c1,
         logic [7:0] c2, logic [7:0] c3, logic [7:0] c4, logic [7:0] tid,
         logic [63:0] now, logic [31:0] age);
      result_type r;
      logic [63:0] tx;
      logic [63:0] rx;
      logic [63:0] tmp;
      logic [63:0] d;
      logic        initial_frame;
      int          key;
      r = '0;
      if (c1[0] == 1'b0) r.apdu_format = FMT_I;
      else if (c1[1:0] == 2'b01) r.apdu_format = FMT_S;
      else r.apdu_format = FMT_U;
      if (len == 8'd0) begin
         r.stop_packet = 1'b1;
      end else if (r.apdu_format == FMT_U) begin
         case (c1[7:2])
            6'h01: r.u_function = UFN_STARTDT_ACT;
            6'h02: r.u_function = UFN_STARTDT_CON;
            6'h04: r.u_function = UFN_STOPDT_ACT;
            6'h08: r.u_function = UFN_STOPDT_CON;
            6'h10: r.u_function = UFN_TESTFR_ACT;
            6'h20: r.u_function = UFN_TESTFR_CON;
            default: r.u_function = UFN_NONE;
         endcase
      end else if (r.apdu_format == FMT_S) begin
         if (len >= 8'd4 && last_i_valid) begin
            r.ack_delay_valid = 1'b1;
            r.ack_delay_us = now - last_i_time;
         end
      end else begin
         last_i_time = now;
         last_i_valid = 1'b1;
         if (len < 8'd6) begin
            r.stop_packet = 1'b1;
         end else begin
            initial_frame = (recv_seq_m == 16'd0) && (send_seq_m == 16'd0);
            tx = {49'd0, c2, c1[7:1]};
            rx = {49'd0, c4, c3[7:1]};
            if (!fwd) begin
               tmp = rx;
               rx = tx;
               tx = tmp;
            end
            if (tx == {48'd0, send_seq_m} && rx == {48'd0, recv_seq_m}) begin
               r.retransmitted = 1'b1;
               r.stop_packet = 1'b1;
            end else begin
               if (!initial_frame) begin
                  tmp = {48'd0, send_seq_m} + 64'd1;
                  d = (tx >= tmp) ? tx - tmp : tmp - tx;
                  if (d != 64'd32768) lost_send_m = add_lost(lost_send_m, d);
                  tmp = {48'd0, recv_seq_m};
                  d = (rx >= tmp) ? rx - tmp : tmp - rx;
                  if (d != 64'd32768) lost_recv_m = add_lost(lost_recv_m, d);
               end
               send_seq_m = tx[15:0];
               recv_seq_m = fwd ? rx[15:0] : rx[15:0] + 16'd1;
               if (!initial_frame) begin
                  key = int'({prev_tid, tid});
                  if (!seen_transition.exists(key)) begin
                     if (age > learn_ms) r.transition_alert = 1'b1;
                     seen_transition[key] = 1'b1;
                  end
               end
               prev_tid = tid;
               if (tid < 8'd64) r.type_alert = !allow_low[tid[5:0]];
               else if (tid < 8'd128) r.type_alert = !allow_high[tid[5:0]];
            end
         end
      end
      r.recv_seq = recv_seq_m;
      r.send_seq = send_seq_m[14:0];
      r.lost_send_total = lost_send_m;
      r.lost_recv_total = lost_recv_m;
      return r;
   endfunction

   task automatic send_request(logic fwd, logic first, logic [7:0] len, logic [7:0] c1,
         logic [7:0] c2, logic [7:0] c3, logic [7:0] c4, logic [7:0] tid,
         logic [63:0] now, logic [31:0] age);
      if ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      push <= 1'b1;
      req_from_initiator <= fwd;
      req_first_of_packet <= first;
      req_apdu_len <= len;
      req_ctrl_one <= c1;
      req_ctrl_two <= c2;
      req_ctrl_three <= c3;
      req_ctrl_four <= c4;
      req_type_id <= tid;
      req_time_us <= now;
      req_flow_age_ms <= age;
      do @(posedge clock); while (full);
      expected_results.push_back(predict_apdu(fwd, len, c1, c2, c3, c4, tid, now, age));
   endtask

   // Sends an I-frame whose sequence numbers are given in the monitor's own view.
   task automatic send_info(logic fwd, logic [14:0] tx, logic [14:0] rx, logic [7:0] tid,
         logic [7:0] len, logic [31:0] age);
      logic [14:0] a;
      logic [14:0] b;
      a = fwd ? tx : rx;
      b = fwd ? rx : tx;
      clock_us = clock_us + $urandom_range(5000);
      send_request(fwd, 1'($urandom_range(1)), len, {a[6:0], 1'b0}, a[14:7],
         {b[6:0], 1'b0}, b[14:7], tid, clock_us, age);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // Leaves room for the pipeline and the table write-back to settle.
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [63:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ALLOW_LOW: allow_low = value;
         CSR_ALLOW_HIGH: allow_high = value;
         default: learn_ms = value[31:0];
      endcase
   endtask

   task automatic send_random_request();
      int          kind;
      logic        fwd;
      logic [14:0] tx;
      logic [14:0] rx;
      logic [7:0]  tid;
      logic [31:0] age;
      kind = $urandom_range(99);
      fwd = ($urandom_range(9) < 7);
      tid = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12));
      age = ($urandom_range(1)) ? $urandom : learn_ms + $urandom_range(4) - 2;
      tx = send_seq_m[14:0] + 15'd1;
      rx = recv_seq_m[14:0];
      if (kind < 55) begin
         if ($urandom_range(9) == 0) tx = tx + 15'($urandom_range(40));
         if ($urandom_range(9) == 0) rx = 15'($urandom);
         send_info(fwd, tx, rx, tid, 8'($urandom_range(255, 6)), age);
      end else if (kind < 63) begin
         send_info(fwd, send_seq_m[14:0], recv_seq_m[14:0], tid, 8'd14, age);
      end else if (kind < 78) begin
         clock_us = clock_us + $urandom_range(20000);
         send_request(fwd, 1'($urandom_range(1)), 8'($urandom_range(7)) + 8'd1, 8'h01,
            8'h00, 8'($urandom), 8'($urandom), 8'($urandom), clock_us, age);
      end else if (kind < 88) begin
         send_request(fwd, 1'($urandom_range(1)), 8'd4,
            {6'd1 << $urandom_range(5), 2'b11},
            8'd0, 8'd0, 8'd0, 8'($urandom), clock_us, age);
      end else begin
         send_request(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom),
            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            {$urandom, $urandom}, $urandom);
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual format %0d", $time,
                  rsp_apdu_format);
               errors++;
            end else begin
               e = expected_results.pop_front();
               check_field("apdu_format", 64'(e.apdu_format), 64'(rsp_apdu_format));
               check_field("u_function", 64'(e.u_function), 64'(rsp_u_function));
               check_field("ack_delay_valid", 64'(e.ack_delay_valid),
                  64'(rsp_ack_delay_valid));
               check_field("ack_delay_us", e.ack_delay_us, rsp_ack_delay_us);
               check_field("recv_seq", 64'(e.recv_seq), 64'(rsp_recv_seq));
               check_field("send_seq", 64'(e.send_seq), 64'(rsp_send_seq));
               check_field("lost_send_total", 64'(e.lost_send_total),
                  64'(rsp_lost_send_total));
               check_field("lost_recv_total", 64'(e.lost_recv_total),
                  64'(rsp_lost_recv_total));
               check_field("retransmitted", 64'(e.retransmitted), 64'(rsp_retransmitted));
               check_field("transition_alert", 64'(e.transition_alert),
                  64'(rsp_transition_alert));
               check_field("type_alert", 64'(e.type_alert), 64'(rsp_type_alert));
               check_field("stop_packet", 64'(e.stop_packet), 64'(rsp_stop_packet));
            end
         end
         if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles - 1;
         end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic test_special_cases();
      // The first I-frame sets the sequences without counting losses.
      send_info(1'b1, 15'd5, 15'd3, 8'd1, 8'd14, 32'd0);
      send_info(1'b1, 15'd6, 15'd3, 8'd3, 8'd14, 32'd0);
      send_info(1'b1, 15'd6, 15'd3, 8'd3, 8'd14, 32'd0);
      send_request(1'b1, 1'b1, 8'd0, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 64'd0, 32'd0);
      send_request(1'b0, 1'b1, 8'd3, 8'h01, 8'd0, 8'd0, 8'd0, 8'd0, 64'd1, 32'd0);
      send_request(1'b0, 1'b0, 8'd4, 8'h01, 8'd0, 8'd0, 8'd0, 8'd0, 64'd0, 32'd0);
      send_request(1'b1, 1'b0, 8'd5, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 64'd100, 32'd0);
      send_request(1'b1, 1'b1, 8'd255, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'd0, '1, '1);
      for (int f = 0; f < 8; f++)
         send_request(1'b1, 1'b0, 8'd4, {6'd1 << f, 2'b11}, 8'd0, 8'd0, 8'd0, 8'd0, 64'd0, 32'd0);
      send_request(1'b1, 1'b0, 8'd4, 8'h03, 8'd0, 8'd0, 8'd0, 8'd0, 64'd0, 32'd0);
      // Sequence wrap: stored send 32767 makes the next expected 32768.
      send_info(1'b1, 15'h7FFF, 15'd3, 8'd200, 8'd6, '1);
      send_info(1'b1, 15'd0, 15'h7FFF, 8'd255, 8'd6, '1);
      send_info(1'b0, 15'd1, 15'd9, 8'd127, 8'd6, '1);
      send_info(1'b0, 15'h7FFF, 15'h7FFF, 8'd64, 8'd200, '1);
   endtask

   task automatic test_random_requests(int count);
      for (int n = 0; n < count; n++) send_random_request();
   endtask

   task automatic test_back_pressure();
      wait_drained();
      hold_cycles = 300;
      for (int n = 0; n < 30; n++) send_random_request();
   endtask

   initial begin
      #30ms;
      $display("iec104_apdu_sequence_monitor_top: mismatch");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      pop <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_ALLOW_LOW;
      csr_wdata <= '0;
      req_from_initiator <= 1'b0;
      req_first_of_packet <= 1'b0;
      req_apdu_len <= '0;
      req_ctrl_one <= '0;
      req_ctrl_two <= '0;
      req_ctrl_three <= '0;
      req_ctrl_four <= '0;
      req_type_id <= '0;
      req_time_us <= '0;
      req_flow_age_ms <= '0;
      allow_low = '1;
      allow_high = '1;
      learn_ms = '0;
      last_i_time = '0;
      last_i_valid = 1'b0;
      prev_tid = '0;
      send_seq_m = '0;
      recv_seq_m = '0;
      lost_send_m = '0;
      lost_recv_m = '0;
      hold_cycles = 0;
      errors = 0;
      clock_us = 64'd1000;
      tx_idle_pct = 7;
      rx_idle_pct = 86;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      write_register(CSR_ALLOW_LOW, 64'h0);
      write_register(CSR_ALLOW_HIGH, {$urandom, $urandom});
      write_register(CSR_LEARN, 64'hFFFF_FFFF);
      test_random_requests(300);
      tx_idle_pct = 86;
      rx_idle_pct = 7;
      test_back_pressure();
      write_register(CSR_ALLOW_LOW, {$urandom, $urandom});
      write_register(CSR_ALLOW_HIGH, 64'h0);
      write_register(CSR_LEARN, 64'd0);
      test_random_requests(500);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_register(CSR_ALLOW_LOW, '1);
      write_register(CSR_ALLOW_HIGH, '1);
      write_register(CSR_LEARN, 64'($urandom));
      test_random_requests(500);
      write_register(CSR_ALLOW_LOW, {$urandom, $urandom});
      write_register(CSR_ALLOW_HIGH, {$urandom, $urandom});
      test_random_requests(500);

      wait_drained();
      if (errors == 0) begin
         $display("iec104_apdu_sequence_monitor_top: match");
      end else begin
         $display("iec104_apdu_sequence_monitor_top: mismatch");
      end
      $finish;
   end

endmodule

[iec104_apdu_sequence_monitor_top.f]
design/iecmon_pkg.sv
design/iecmon_front.sv
design/iecmon_back.sv
design/iec104_apdu_sequence_monitor_top.sv
sim/iec104_apdu_sequence_monitor_top_test.sv
